// ----- sv/mpt_pkg.sv -----
// package for the multichannel pulse timer: widths, codes and controller types
package mpt_pkg;

  localparam int unsigned NumSlots   = 4;
  localparam int unsigned PinW       = 6;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned DefDurW    = 20;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned ActionW    = 2;
  localparam int unsigned SlotOutW   = 2;

  localparam logic [DefDurW-1:0] ResetDefaultMs = DefDurW'(1000);
  localparam logic [TimeW-1:0]   ResetMaxMs     = TimeW'(600000);

  localparam logic [CfgIdxW-1:0] CFG_DEFAULT_DUR = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_MAX_DUR     = CfgIdxW'(1);

  localparam logic OP_PULSE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [ActionW-1:0] {
    ACT_HIGH   = 2'd0,
    ACT_LOW    = 2'd1,
    ACT_STATUS = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_HIGH,
    EMIT_LOW,
    EMIT_STATUS
  } emit_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_CLAIM,
    ST_HIGH,
    ST_SCAN,
    ST_STATUS
  } state_e;

  typedef struct packed {
    logic  load;
    logic  clamp;
    logic  claim;
    logic  release_slot;
    logic  mark_active;
    logic  step;
    emit_e emit;
  } cmd_t;

  typedef struct packed {
    logic pin_zero;
    logic slot_match;
    logic slot_busy;
    logic slot_expired;
    logic idx_last;
    logic out_free;
  } status_t;

endpackage

// ----- sv/mpt_intf.sv -----
// item channel interfaces of the multichannel pulse timer
interface mpt_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [mpt_pkg::PinW-1:0]      pin;
  logic [mpt_pkg::TimeW-1:0]     duration_ms;
  logic [mpt_pkg::TimeW-1:0]     now_ms;

  modport source (output valid, op, pin, duration_ms, now_ms, input ready);
  modport sink   (input valid, op, pin, duration_ms, now_ms, output ready);
endinterface

interface mpt_out_if;
  logic                          valid;
  logic                          ready;
  logic [mpt_pkg::ActionW-1:0]   action;
  logic [mpt_pkg::PinW-1:0]      pin_out;
  logic [mpt_pkg::SlotOutW-1:0]  slot_index;
  logic                          slot_found;
  logic                          any_active;
  logic                          last;

  modport source (output valid, action, pin_out, slot_index, slot_found, any_active, last,
                  input ready);
  modport sink   (input valid, action, pin_out, slot_index, slot_found, any_active, last,
                  output ready);
endinterface

// ----- sv/mpt_ctrl.sv -----
// controller state machine of the multichannel pulse timer
module mpt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_op_i,
  output logic             in_ready_o,
  input  mpt_pkg::status_t status_i,
  output mpt_pkg::cmd_t    cmd_o
);

  mpt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.emit = mpt_pkg::EMIT_NONE;
    case (state_q)
      mpt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_op_i == mpt_pkg::OP_TICK) ? mpt_pkg::ST_SCAN : mpt_pkg::ST_CLAMP;
        end
      end
      mpt_pkg::ST_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = status_i.pin_zero ? mpt_pkg::ST_HIGH : mpt_pkg::ST_CLAIM;
      end
      mpt_pkg::ST_CLAIM: begin
        if (status_i.slot_match) begin
          cmd_o.claim = 1'b1;
          state_d     = mpt_pkg::ST_HIGH;
        end else if (status_i.idx_last) begin
          state_d = mpt_pkg::ST_HIGH;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      mpt_pkg::ST_HIGH: begin
        if (status_i.out_free) begin
          cmd_o.emit = mpt_pkg::EMIT_HIGH;
          state_d    = mpt_pkg::ST_IDLE;
        end
      end
      mpt_pkg::ST_SCAN: begin
        if (!status_i.slot_busy || !status_i.slot_expired || status_i.out_free) begin
          if (status_i.slot_busy && status_i.slot_expired) begin
            cmd_o.emit         = mpt_pkg::EMIT_LOW;
            cmd_o.release_slot = 1'b1;
          end else if (status_i.slot_busy) begin
            cmd_o.mark_active = 1'b1;
          end
          if (status_i.idx_last) begin
            state_d = mpt_pkg::ST_STATUS;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      mpt_pkg::ST_STATUS: begin
        if (status_i.out_free) begin
          cmd_o.emit = mpt_pkg::EMIT_STATUS;
          state_d    = mpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mpt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/mpt_dp.sv -----
// datapath of the multichannel pulse timer: config, slot table, clamp, deadline and result register
module mpt_dp #(
  parameter int unsigned NUM_SLOTS = mpt_pkg::NumSlots
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mpt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mpt_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic [mpt_pkg::PinW-1:0]       in_pin_i,
  input  logic [mpt_pkg::TimeW-1:0]      in_duration_i,
  input  logic [mpt_pkg::TimeW-1:0]      in_now_i,
  input  mpt_pkg::cmd_t                  cmd_i,
  output mpt_pkg::status_t               status_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mpt_pkg::ActionW-1:0]    out_action_o,
  output logic [mpt_pkg::PinW-1:0]       out_pin_o,
  output logic [mpt_pkg::SlotOutW-1:0]   out_slot_o,
  output logic                           out_found_o,
  output logic                           out_active_o,
  output logic                           out_last_o
);

  localparam int unsigned SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned ExtW  = SlotW + mpt_pkg::SlotOutW;
  localparam int unsigned TW    = mpt_pkg::TimeW;

  logic [mpt_pkg::DefDurW-1:0] def_dur_q;
  logic [TW-1:0]               max_dur_q;

  logic [mpt_pkg::PinW-1:0] pin_q;
  logic [TW-1:0]            dur_q, dur_d;
  logic [TW-1:0]            now_q;
  logic [SlotW-1:0]         idx_q;
  logic                     found_q;
  logic                     active_q;

  logic [mpt_pkg::PinW-1:0] slot_pin_q [NUM_SLOTS];
  logic [TW-1:0]            slot_dl_q  [NUM_SLOTS];

  logic                          out_valid_q;
  logic [mpt_pkg::ActionW-1:0]   out_action_q;
  logic [mpt_pkg::PinW-1:0]      out_pin_q;
  logic [mpt_pkg::SlotOutW-1:0]  out_slot_q;
  logic                          out_found_q;
  logic                          out_active_q;
  logic                          out_last_q;

  logic [mpt_pkg::PinW-1:0] cur_pin;
  logic [TW-1:0]            cur_dl;
  logic [TW-1:0]            diff;
  logic [TW-1:0]            dur_sel;
  logic [TW-1:0]            new_dl;
  logic [ExtW-1:0]          idx_ext;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_dur_q <= mpt_pkg::ResetDefaultMs;
      max_dur_q <= mpt_pkg::ResetMaxMs;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mpt_pkg::CFG_DEFAULT_DUR: def_dur_q <= cfg_data_i[mpt_pkg::DefDurW-1:0];
        mpt_pkg::CFG_MAX_DUR:     max_dur_q <= cfg_data_i[TW-1:0];
        default: ;
      endcase
    end
  end

  assign cur_pin = slot_pin_q[idx_q];
  assign cur_dl  = slot_dl_q[idx_q];
  assign diff    = now_q - cur_dl;
  assign idx_ext = ExtW'(idx_q);

  assign dur_sel = (dur_q == '0) ? TW'(def_dur_q) : dur_q;
  assign dur_d   = (dur_sel > max_dur_q) ? max_dur_q : dur_sel;
  assign new_dl  = ((now_q + dur_q) == '0) ? TW'(1) : (now_q + dur_q);

  assign status_o.pin_zero     = (pin_q == '0);
  assign status_o.slot_match   = (cur_pin == '0) || (cur_pin == pin_q);
  assign status_o.slot_busy    = (cur_pin != '0);
  assign status_o.slot_expired = (cur_dl != '0) && !diff[TW-1];
  assign status_o.idx_last     = (idx_q == SlotW'(NUM_SLOTS - 1));
  assign status_o.out_free     = !out_valid_q || out_ready_i;

  // item registers and scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      found_q  <= 1'b0;
      active_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q    <= '0;
        found_q  <= 1'b0;
        active_q <= 1'b0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + SlotW'(1);
      end
      if (cmd_i.claim) begin
        found_q <= 1'b1;
      end
      if (cmd_i.mark_active) begin
        active_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pin_q <= in_pin_i;
      dur_q <= in_duration_i;
      now_q <= in_now_i;
    end else if (cmd_i.clamp) begin
      dur_q <= dur_d;
    end
  end

  // slot table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_pin_q[i] <= '0;
      end
    end else if (cmd_i.claim) begin
      slot_pin_q[idx_q] <= pin_q;
    end else if (cmd_i.release_slot) begin
      slot_pin_q[idx_q] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.claim) begin
      slot_dl_q[idx_q] <= new_dl;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit != mpt_pkg::EMIT_NONE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.emit)
      mpt_pkg::EMIT_HIGH: begin
        out_action_q <= mpt_pkg::ACT_HIGH;
        out_pin_q    <= pin_q;
        out_slot_q   <= found_q ? idx_ext[mpt_pkg::SlotOutW-1:0] : '0;
        out_found_q  <= found_q;
        out_active_q <= 1'b0;
        out_last_q   <= 1'b1;
      end
      mpt_pkg::EMIT_LOW: begin
        out_action_q <= mpt_pkg::ACT_LOW;
        out_pin_q    <= cur_pin;
        out_slot_q   <= idx_ext[mpt_pkg::SlotOutW-1:0];
        out_found_q  <= 1'b0;
        out_active_q <= 1'b0;
        out_last_q   <= 1'b0;
      end
      mpt_pkg::EMIT_STATUS: begin
        out_action_q <= mpt_pkg::ACT_STATUS;
        out_pin_q    <= '0;
        out_slot_q   <= '0;
        out_found_q  <= 1'b0;
        out_active_q <= active_q;
        out_last_q   <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_action_o = out_action_q;
  assign out_pin_o    = out_pin_q;
  assign out_slot_o   = out_slot_q;
  assign out_found_o  = out_found_q;
  assign out_active_o = out_active_q;
  assign out_last_o   = out_last_q;

endmodule

// ----- sv/multichannel_pulse_timer.sv -----
// top level of the multichannel pulse timer
//
// in_i carries one item per handshake: a pulse request (op 0) with pin and
// duration, or a tick (op 1) with the current time. out_o carries results.
// A pulse gives one drive-high item; a tick gives one drive-low item per
// expired slot and then a status item, the last one flagged with last.
// cfg_we_i/cfg_idx_i/cfg_data_i write the default and maximum durations.
// Steps: a pulse is accepted and its duration clamped; for a nonzero pin,
// slots are looked at from index 0 until one is free or matches (all
// NUM_SLOTS when none does), then the drive-high item goes out. A tick
// looks at each slot in turn via the shared slot-table read port, then
// emits the status item. A new item is taken once the previous one is
// finished, while its last result may still wait in the output register.
// When the receiver stalls, the output register holds its item and the
// scan stops at the next slot that needs to emit.
// Reset empties all slots and loads default 1000 ms and maximum 600000 ms.
module multichannel_pulse_timer #(
  parameter int unsigned NUM_SLOTS = mpt_pkg::NumSlots
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mpt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mpt_pkg::CfgDataW-1:0]  cfg_data_i,
  mpt_in_if.sink                        in_i,
  mpt_out_if.source                     out_o
);

  mpt_pkg::cmd_t    cmd;
  mpt_pkg::status_t status;

  mpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mpt_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_pin_i      (in_i.pin),
    .in_duration_i (in_i.duration_ms),
    .in_now_i      (in_i.now_ms),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_action_o  (out_o.action),
    .out_pin_o     (out_o.pin_out),
    .out_slot_o    (out_o.slot_index),
    .out_found_o   (out_o.slot_found),
    .out_active_o  (out_o.any_active),
    .out_last_o    (out_o.last)
  );

endmodule

// ----- sv/mpt_checker.sv -----
// port checker of the multichannel pulse timer and its bind
module mpt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [mpt_pkg::ActionW-1:0]   action_i,
  input logic [mpt_pkg::PinW-1:0]      pin_out_i,
  input logic [mpt_pkg::SlotOutW-1:0]  slot_index_i,
  input logic                          slot_found_i,
  input logic                          any_active_i,
  input logic                          last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(action_i) &&
      $stable(pin_out_i) && $stable(slot_index_i) && $stable(last_i))
    else $error("stalled output item changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again right after an accept");

  a_status_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && action_i == mpt_pkg::ACT_STATUS |->
      last_i && pin_out_i == '0 && slot_index_i == '0 && !slot_found_i)
    else $error("malformed status item");

  a_low_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && action_i == mpt_pkg::ACT_LOW |->
      !last_i && pin_out_i != '0 && !any_active_i && !slot_found_i)
    else $error("malformed pin-low item");

  a_high_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && action_i == mpt_pkg::ACT_HIGH && !slot_found_i |->
      slot_index_i == '0 && last_i)
    else $error("pin-high item without slot has a slot index");

endmodule

bind multichannel_pulse_timer mpt_checker u_mpt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .action_i     (out_o.action),
  .pin_out_i    (out_o.pin_out),
  .slot_index_i (out_o.slot_index),
  .slot_found_i (out_o.slot_found),
  .any_active_i (out_o.any_active),
  .last_i       (out_o.last)
);
